[src/tsla_pkg.sv]
// Shared types and operation codes for the Thumb shift/logic ALU.
// No dependencies; every other file imports this package.
package tsla_pkg;

    localparam int DataWidth = 32;
    localparam int OpWidth   = 4;

    localparam logic [OpWidth-1:0] OP_LSLS  = 4'd0;
    localparam logic [OpWidth-1:0] OP_LSRS  = 4'd1;
    localparam logic [OpWidth-1:0] OP_ASRS  = 4'd2;
    localparam logic [OpWidth-1:0] OP_RORS  = 4'd3;
    localparam logic [OpWidth-1:0] OP_BICS  = 4'd4;
    localparam logic [OpWidth-1:0] OP_MVNS  = 4'd5;
    localparam logic [OpWidth-1:0] OP_CMN   = 4'd6;
    localparam logic [OpWidth-1:0] OP_CMP   = 4'd7;
    localparam logic [OpWidth-1:0] OP_RSBS  = 4'd8;
    localparam logic [OpWidth-1:0] OP_REV   = 4'd9;
    localparam logic [OpWidth-1:0] OP_REV16 = 4'd10;
    localparam logic [OpWidth-1:0] OP_REVSH = 4'd11;
    localparam logic [OpWidth-1:0] OP_TST   = 4'd12;

    // Field widths of the stream words
    localparam int InDataBits  = OpWidth + 2 * DataWidth;
    localparam int InDataBytes = (InDataBits + 7) / 8;
    localparam int OutDataBits = DataWidth + 5;
    localparam int OutDataBytes = (OutDataBits + 7) / 8;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [DataWidth-1:0] result;
        logic                 writes_result;
        flags_t               flags;
    } alu_out_t;

endpackage

[src/tsla_alu.sv]
// Combinational datapath: shifter, logic unit, adder and byte reversal.
// Depends on tsla_pkg for operation codes and the flag/result structs.
module tsla_alu
    import tsla_pkg::*;
(
    input  logic [OpWidth-1:0]   operation,
    input  logic [DataWidth-1:0] operand_a,
    input  logic [DataWidth-1:0] operand_b,
    input  flags_t               flags_in,
    output alu_out_t             alu_out
);

    logic [7:0]           amount;
    logic [4:0]           amount_lo;
    logic                 amount_zero;
    logic                 amount_lt32;
    logic                 amount_eq32;
    logic [DataWidth:0]   shl_wide;
    logic [DataWidth:0]   shr_wide;
    logic [DataWidth:0]   asr_wide;
    logic [2*DataWidth-1:0] ror_wide;
    logic [DataWidth-1:0] add_x;
    logic [DataWidth-1:0] add_y;
    logic                 add_cin;
    logic [DataWidth:0]   add_sum;

    assign amount      = operand_b[7:0];
    assign amount_lo   = amount[4:0];
    assign amount_zero = (amount == 8'd0);
    assign amount_lt32 = (amount[7:5] == 3'd0);
    assign amount_eq32 = (amount == 8'd32);

    // Extra bit beyond the word catches the last bit shifted out
    assign shl_wide = {1'b0, operand_a} << amount_lo;
    assign shr_wide = {operand_a, 1'b0} >> amount_lo;
    assign asr_wide = $unsigned($signed({operand_a, 1'b0}) >>> amount_lo);
    assign ror_wide = {operand_a, operand_a} >> amount_lo;

    always_comb begin
        add_x   = operand_a;
        add_y   = operand_b;
        add_cin = 1'b0;
        case (operation)
            OP_CMP: begin
                add_y   = ~operand_b;
                add_cin = 1'b1;
            end
            OP_RSBS: begin
                add_x   = ~operand_a;
                add_y   = '0;
                add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataWidth{1'b0}}, add_cin};

    always_comb begin
        logic [DataWidth-1:0] r;
        logic                 wr;
        logic                 set_nz;
        flags_t               f;
        r      = '0;
        wr     = 1'b1;
        set_nz = 1'b1;
        f      = flags_in;
        case (operation)
            OP_LSLS: begin
                if (amount_zero) begin
                    r = operand_a;
                end else if (amount_lt32) begin
                    r   = shl_wide[DataWidth-1:0];
                    f.c = shl_wide[DataWidth];
                end else begin
                    r   = '0;
                    f.c = amount_eq32 & operand_a[0];
                end
            end
            OP_LSRS: begin
                if (amount_zero) begin
                    r = operand_a;
                end else if (amount_lt32) begin
                    r   = shr_wide[DataWidth:1];
                    f.c = shr_wide[0];
                end else begin
                    r   = '0;
                    f.c = amount_eq32 & operand_a[DataWidth-1];
                end
            end
            OP_ASRS: begin
                if (amount_zero) begin
                    r = operand_a;
                end else if (amount_lt32) begin
                    r   = asr_wide[DataWidth:1];
                    f.c = asr_wide[0];
                end else begin
                    r   = {DataWidth{operand_a[DataWidth-1]}};
                    f.c = operand_a[DataWidth-1];
                end
            end
            OP_RORS: begin
                if (amount_zero) begin
                    r = operand_a;
                end else begin
                    r   = ror_wide[DataWidth-1:0];
                    f.c = r[DataWidth-1];
                end
            end
            OP_BICS: r = operand_a & ~operand_b;
            OP_MVNS: r = ~operand_a;
            OP_CMN, OP_CMP, OP_RSBS: begin
                r   = add_sum[DataWidth-1:0];
                f.c = add_sum[DataWidth];
                f.v = ~(add_x[DataWidth-1] ^ add_y[DataWidth-1])
                    & (add_x[DataWidth-1] ^ r[DataWidth-1]);
                wr  = (operation == OP_RSBS);
            end
            OP_REV: begin
                r      = {operand_a[7:0], operand_a[15:8], operand_a[23:16], operand_a[31:24]};
                set_nz = 1'b0;
            end
            OP_REV16: begin
                r      = {operand_a[23:16], operand_a[31:24], operand_a[7:0], operand_a[15:8]};
                set_nz = 1'b0;
            end
            OP_REVSH: begin
                r      = {{16{operand_a[7]}}, operand_a[7:0], operand_a[15:8]};
                set_nz = 1'b0;
            end
            OP_TST: begin
                r  = operand_a & operand_b;
                wr = 1'b0;
            end
            default: begin
                r      = '0;
                wr     = 1'b0;
                set_nz = 1'b0;
            end
        endcase
        if (set_nz) begin
            f.n = r[DataWidth-1];
            f.z = (r == '0);
        end
        alu_out.result        = r;
        alu_out.writes_result = wr;
        alu_out.flags         = f;
    end

endmodule

[src/thumb_shift_logic_alu_unit.sv]
// Top level of the Thumb shift/logic ALU: stream ports, operand and result
// registers, and the stored condition flags. Depends on tsla_pkg, tsla_alu.
//
//  channel  | dir | tdata fields (low bit first)
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | operation[3:0], operand_a[35:4], operand_b[67:36], pad
//  m_axis   | out | result[31:0], writes_result, flag_n, flag_z, flag_c, flag_v
//
// One transaction per clock sustained while m_tready is high; an accepted input
// passes through the operand register, then the result register.
// The flags loop closes through the single ALU stage, so dependent items
// run back to back. aresetn (sync, active low) clears valids and flags.
// A stalled result holds the ALU stage; input is still taken while the
// operand register is empty.
module thumb_shift_logic_alu_unit
    import tsla_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // operation[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  logic [8*InDataBytes-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // result[31:0], writes_result[32], flag_n[33], flag_z[34], flag_c[35],
    // flag_v[36], zero pad
    output logic [8*OutDataBytes-1:0] m_tdata
);

    logic                 in_valid_reg;
    logic [OpWidth-1:0]   op_reg;
    logic [DataWidth-1:0] a_reg;
    logic [DataWidth-1:0] b_reg;
    logic                 out_valid_reg;
    alu_out_t             out_reg;
    flags_t               flags_reg;
    flags_t               flags_next;
    alu_out_t             alu_out;
    logic                 advance;

    // Result register free or emptying this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    tsla_alu u_alu (
        .operation (op_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .flags_in  (flags_reg),
        .alu_out   (alu_out)
    );

    assign flags_next = (in_valid_reg && advance) ? alu_out.flags : flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            flags_reg <= flags_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= s_tdata[OpWidth-1:0];
            a_reg  <= s_tdata[OpWidth+DataWidth-1:OpWidth];
            b_reg  <= s_tdata[OpWidth+2*DataWidth-1:OpWidth+DataWidth];
        end
        if (advance && in_valid_reg) begin
            out_reg <= alu_out;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8*OutDataBytes-OutDataBits){1'b0}},
                       out_reg.flags.v, out_reg.flags.c, out_reg.flags.z, out_reg.flags.n,
                       out_reg.writes_result, out_reg.result};

    // Flags change only when an item leaves the ALU stage
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_valid_reg && advance) |=> $stable(flags_reg))
        else $error("flags changed without an item passing the ALU");

    // The presented result carries the current stored flags
    a_flags_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.flags == flags_reg))
        else $error("result flags differ from stored flags");

    // An empty operand register always takes input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with empty operand register");

    // A new result only appears from a valid operand stage
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result valid without an operand in flight");

endmodule
